@@ src/ipa_pkg.sv @@
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared types, codes and lookup tables of the interrupt priority arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipa_pkg;

  // transaction kinds
  localparam logic FUNC_LINE  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // line codes for line-change transactions
  localparam logic [2:0] LINE_VECTOR = 3'd4;
  localparam logic [2:0] LINE_PWR    = 3'd5;
  localparam logic [2:0] LINE_BUS    = 3'd6;
  localparam logic [2:0] LINE_HALT   = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_BOOT_PC = 2'd0;
  localparam logic [1:0] CFG_BUS_VEC = 2'd1;
  localparam logic [1:0] CFG_PWR_VEC = 2'd2;

  localparam logic [15:0] BOOT_PC_RST     = 16'hC000;
  localparam logic [7:0]  BUS_VEC_RST     = 8'd4;
  localparam logic [7:0]  PWR_VEC_RST     = 8'd20;
  localparam logic [15:0] RESTART_OFFSET  = 16'd4;
  localparam logic [7:0]  VEC_ALIGN_MASK  = 8'hFC;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_HALT = 2'd1,
    ACT_TRAP = 2'd2
  } action_t;

  typedef struct packed {
    logic [3:0] coded_levels;
    logic       vector_line;
    logic       halt_pending;
    logic       bus_pending;
    logic       pwr_pending;
  } ipa_status_t;

  typedef struct packed {
    logic halt;
    logic bus;
    logic pwr;
  } ipa_take_t;

  typedef struct packed {
    logic [15:0] boot_pc;
    logic [7:0]  bus_vec;
    logic [7:0]  pwr_vec;
  } ipa_cfg_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  trap_vector;
    logic [15:0] restart_pc;
    logic        ack_issued;
    logic [4:0]  ack_code;
    logic [3:0]  taken_level;
  } ipa_result_t;

  function automatic logic [2:0] level_prio(input logic [3:0] lvl);
    logic [2:0] p;
    case (lvl[3:2])
      2'd0:    p = (lvl[1:0] == 2'd0) ? 3'd0 : 3'd4;
      2'd1:    p = 3'd5;
      2'd2:    p = 3'd6;
      default: p = 3'd7;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] level_vec(input logic [3:0] lvl);
    logic [7:0] v;
    case (lvl)
      4'd0:    v = 8'o000;
      4'd1:    v = 8'o070;
      4'd2:    v = 8'o064;
      4'd3:    v = 8'o060;
      4'd4:    v = 8'o134;
      4'd5:    v = 8'o130;
      4'd6:    v = 8'o124;
      4'd7:    v = 8'o120;
      4'd8:    v = 8'o114;
      4'd9:    v = 8'o110;
      4'd10:   v = 8'o104;
      4'd11:   v = 8'o100;
      4'd12:   v = 8'o154;
      4'd13:   v = 8'o150;
      4'd14:   v = 8'o144;
      default: v = 8'o140;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/ipa_lines.sv @@
// ----------------------------------------------------------------------------
// ipa_lines
// Line state: coded levels, vector line and edge-detected pending flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipa_lines (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              line_en,
  input  wire logic [2:0]        line,
  input  wire logic              asserted,
  input  wire logic              check_en,
  input  wire ipa_pkg::ipa_take_t take,
  output ipa_pkg::ipa_status_t   status
);
  import ipa_pkg::*;

  logic [3:0] coded_r;
  logic       vector_r;
  logic       pwr_seen_r, pwr_pend_r;
  logic       bus_seen_r, bus_pend_r;
  logic       halt_seen_r, halt_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coded_r     <= '0;
      vector_r    <= 1'b0;
      pwr_seen_r  <= 1'b0;
      pwr_pend_r  <= 1'b0;
      bus_seen_r  <= 1'b0;
      bus_pend_r  <= 1'b0;
      halt_seen_r <= 1'b0;
      halt_pend_r <= 1'b0;
    end else if (line_en) begin
      if (!line[2]) begin
        coded_r[line[1:0]] <= asserted;
      end else begin
        case (line)
          LINE_VECTOR: vector_r <= asserted;
          LINE_PWR: begin
            // rising edge only
            if (asserted && !pwr_seen_r) pwr_pend_r <= 1'b1;
            pwr_seen_r <= asserted;
          end
          LINE_BUS: begin
            if (asserted && !bus_seen_r) bus_pend_r <= 1'b1;
            bus_seen_r <= asserted;
          end
          LINE_HALT: begin
            if (asserted && !halt_seen_r) halt_pend_r <= 1'b1;
            halt_seen_r <= asserted;
          end
          default: ;
        endcase
      end
    end else if (check_en) begin
      if (take.halt) halt_pend_r <= 1'b0;
      if (take.bus)  bus_pend_r  <= 1'b0;
      if (take.pwr)  pwr_pend_r  <= 1'b0;
    end
  end

  assign status.coded_levels = coded_r;
  assign status.vector_line  = vector_r;
  assign status.halt_pending = halt_pend_r;
  assign status.bus_pending  = bus_pend_r;
  assign status.pwr_pending  = pwr_pend_r;

endmodule

`default_nettype wire

@@ src/ipa_resolve.sv @@
// ----------------------------------------------------------------------------
// ipa_resolve
// Priority chain: halt, bus error, power fail, then coded level vs PSW.
// ----------------------------------------------------------------------------
`default_nettype none

module ipa_resolve (
  input  wire ipa_pkg::ipa_status_t status,
  input  wire ipa_pkg::ipa_cfg_t    cfg,
  input  wire logic [2:0]           psw_priority,
  input  wire logic [7:0]           ack_vector,
  output ipa_pkg::ipa_result_t      result,
  output ipa_pkg::ipa_take_t        take
);
  import ipa_pkg::*;

  logic [3:0] lvl;
  logic [4:0] code;

  assign lvl = status.coded_levels;
  // inverted level, bit-reversed; bit 4 marks non-vectored
  assign code = {~status.vector_line, ~lvl[0], ~lvl[1], ~lvl[2], ~lvl[3]};

  always_comb begin
    result = '0;
    take   = '0;
    if (status.halt_pending) begin
      take.halt         = 1'b1;
      result.action     = ACT_HALT;
      result.restart_pc = cfg.boot_pc + RESTART_OFFSET;
    end else if (status.bus_pending) begin
      take.bus           = 1'b1;
      result.action      = ACT_TRAP;
      result.trap_vector = cfg.bus_vec & VEC_ALIGN_MASK;
    end else if (status.pwr_pending) begin
      take.pwr           = 1'b1;
      result.action      = ACT_TRAP;
      result.trap_vector = cfg.pwr_vec & VEC_ALIGN_MASK;
    end else if (level_prio(lvl) > psw_priority) begin
      result.action      = ACT_TRAP;
      result.trap_vector = code[4] ? level_vec(lvl) : (ack_vector & VEC_ALIGN_MASK);
      result.ack_issued  = 1'b1;
      result.ack_code    = code;
      result.taken_level = lvl;
    end
  end

endmodule

`default_nettype wire

@@ src/cpu_interrupt_priority_arbiter.sv @@
// ----------------------------------------------------------------------------
// cpu_interrupt_priority_arbiter
// Interrupt and trap arbiter with coded priority lines and edge-detected traps.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item. in_func 0 changes a line (no result),
//           in_func 1 checks interrupts at an instruction boundary and gives
//           exactly one result transaction on out_*.
//   cfg_* : register writes (0 initial PC, 1 bus-error vector, 2 power-fail
//           vector); cfg_ready is always high, index 3 is ignored.
// Timing: a check in the input register is resolved combinationally and its
//   result is registered when the result register is free.
// Throughput: one transaction per cycle unless stalled (see Stall); the input
//   register and the result register each hold one item, so a new transaction is
//   taken while a finished result waits for out_ready.
// Stall: when out_ready is low and a result is held, a check in the input
//   register waits and in_ready follows; line changes keep flowing behind a
//   held result only until a check reaches the input register.
// Reset: rst_n low clears all lines, pending flags, both stages and loads
//   the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_interrupt_priority_arbiter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [2:0]  in_line,
  input  wire logic        in_asserted,
  input  wire logic [2:0]  in_psw_priority,
  input  wire logic [7:0]  in_ack_vector,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_action,
  output logic [7:0]       out_trap_vector,
  output logic [15:0]      out_restart_pc,
  output logic             out_ack_issued,
  output logic [4:0]       out_ack_code,
  output logic [3:0]       out_taken_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ipa_pkg::*;

  ipa_cfg_t    cfg_r;
  logic        s1_valid_r;
  logic        s1_func_r;
  logic [2:0]  s1_line_r;
  logic        s1_asserted_r;
  logic [2:0]  s1_psw_r;
  logic [7:0]  s1_ackvec_r;
  logic        out_valid_r;
  ipa_result_t out_r;

  ipa_status_t status;
  ipa_take_t   take;
  ipa_result_t result;
  logic        out_free;
  logic        s1_adv;
  logic        line_en;
  logic        check_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_pc <= BOOT_PC_RST;
      cfg_r.bus_vec <= BUS_VEC_RST;
      cfg_r.pwr_vec <= PWR_VEC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOOT_PC: cfg_r.boot_pc <= cfg_data;
        CFG_BUS_VEC: cfg_r.bus_vec <= cfg_data[7:0];
        CFG_PWR_VEC: cfg_r.pwr_vec <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && ((s1_func_r == FUNC_LINE) || out_free);
  assign line_en  = s1_valid_r && (s1_func_r == FUNC_LINE);
  assign check_en = s1_valid_r && (s1_func_r == FUNC_CHECK) && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_func_r     <= in_func;
      s1_line_r     <= in_line;
      s1_asserted_r <= in_asserted;
      s1_psw_r      <= in_psw_priority;
      s1_ackvec_r   <= in_ack_vector;
    end
  end

  ipa_lines u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .line_en  (line_en),
    .line     (s1_line_r),
    .asserted (s1_asserted_r),
    .check_en (check_en),
    .take     (take),
    .status   (status)
  );

  ipa_resolve u_resolve (
    .status       (status),
    .cfg          (cfg_r),
    .psw_priority (s1_psw_r),
    .ack_vector   (s1_ackvec_r),
    .result       (result),
    .take         (take)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= check_en;
    end
    if (check_en) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_trap_vector = out_r.trap_vector;
  assign out_restart_pc  = out_r.restart_pc;
  assign out_ack_issued  = out_r.ack_issued;
  assign out_ack_code    = out_r.ack_code;
  assign out_taken_level = out_r.taken_level;

endmodule

`default_nettype wire
